// ===== sv/psgh_pkg.sv =====
// Shared constants, types and helper functions for the path string guid hash unit.
package psgh_pkg;

	localparam int unsigned WordWidth  = 32;
	localparam int unsigned HashWidth  = 64;
	localparam int unsigned TermWidth  = 40;
	localparam int unsigned WcntWidth  = 30;

	localparam logic [31:0] BslashPat  = 32'h5C5C5C5C;
	localparam logic [31:0] ByteOnes   = 32'h01010101;
	localparam logic [31:0] CaseMask   = 32'hDFDFDFDF;
	localparam logic [31:0] ByteHigh   = 32'h80808080;
	localparam logic [31:0] BslashStep = 32'd45;

	localparam logic [63:0] HashK1     = 64'h00000FB8C4D96501;
	localparam logic [63:0] HashKm     = 64'h000000000633D5F1;
	localparam logic [63:0] HashK2     = 64'h00AE502812AA7333;

	// Per-word step of the scaled count, and the correction when the count wraps.
	localparam logic [63:0] K2Word     = HashK2 << 2;
	localparam logic [63:0] K2Wrap     = HashK2 << 32;

	// One folded word on its way from the front stage to the accumulator.
	typedef struct packed {
		logic                 term;
		logic [1:0]           tail;
		logic [TermWidth-1:0] term_val;
	} psgh_word_t;

	// Multiples of the count constant for the bytes before the terminator.
	function automatic logic [63:0] k2_times(input logic [1:0] k);
		logic [63:0] r;
		begin
			case (k)
				2'd0:    r = 64'h0;
				2'd1:    r = HashK2;
				2'd2:    r = HashK2 << 1;
				2'd3:    r = (HashK2 << 1) + HashK2;
				default: r = 64'h0;
			endcase
			return r;
		end
	endfunction

endpackage

// ===== sv/psgh_fold.sv =====
// Front stage: input register, character folding, terminator search and the K1 product.
module psgh_fold import psgh_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [WordWidth-1:0] text_word,
	output logic                 word_valid,
	output psgh_word_t           word_data,
	input  logic                 word_take
);

	logic                 valid_s1;
	logic [WordWidth-1:0] word_s1;
	logic                 valid_s2;
	psgh_word_t           data_s2;
	logic                 adv_s1;

	logic [31:0] x;
	logic [31:0] flags;
	logic [31:0] folded;
	logic [31:0] z;
	logic [31:0] low;
	logic [31:0] keep;
	logic [31:0] sel;
	logic [63:0] prod;
	logic [1:0]  tail;

	// The first stage moves on when the second is empty or being drained.
	assign adv_s1   = valid_s1 && (!valid_s2 || word_take);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_s1 <= text_word;
		end
	end

	// Backslash to slash, then case fold.
	always_comb begin
		x      = word_s1 ^ BslashPat;
		flags  = ((~x) >> 7) & ((x - ByteOnes) >> 7) & ByteOnes;
		folded = (word_s1 - 32'(flags * BslashStep)) & CaseMask;
	end

	// Terminator search: the lowest flagged byte ends the string.
	always_comb begin
		z    = (~word_s1) & (word_s1 - ByteOnes) & ByteHigh;
		low  = z & (32'h0 - z);
		keep = low - 32'h1;
		if (z[7]) begin
			tail = 2'd0;
		end else if (z[15]) begin
			tail = 2'd1;
		end else if (z[23]) begin
			tail = 2'd2;
		end else begin
			tail = 2'd3;
		end
	end

	// Scaled word term, truncated to 64 bits and shifted down by 24.
	always_comb begin
		sel  = (z != 32'h0) ? (folded & keep) : folded;
		prod = HashK1 * {32'h0, sel};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || word_take) begin
			valid_s2 <= adv_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			data_s2.term     <= (z != 32'h0);
			data_s2.tail     <= tail;
			data_s2.term_val <= prod[63:24];
		end
	end

	assign word_valid = valid_s2;
	assign word_data  = data_s2;

endmodule

// ===== sv/psgh_accum.sv =====
// Hash accumulator: running hash, scaled byte count and the guid result register.
module psgh_accum import psgh_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 word_valid,
	input  psgh_word_t           word_data,
	output logic                 word_take,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [HashWidth-1:0] guid
);

	logic [HashWidth-1:0] hash_q;
	logic [WcntWidth-1:0] wcnt_q;
	logic [63:0]          kcnt_q;
	logic                 out_valid_q;
	logic [HashWidth-1:0] guid_q;

	logic                 out_free;
	logic [63:0]          mix;
	logic [63:0]          sum;
	logic [63:0]          kcnt_next;
	logic [63:0]          guid_next;

	// A terminator beat needs the result register; other beats never wait.
	assign out_free  = !out_valid_q || out_ready;
	assign word_take = word_valid && (!word_data.term || out_free);

	// The count is kept pre-multiplied by K2, so the count term of the guid needs no multiplier.
	always_comb begin
		mix       = HashKm * hash_q;
		sum       = mix + {24'h0, word_data.term_val};
		kcnt_next = kcnt_q + K2Word - ((&wcnt_q) ? K2Wrap : 64'h0);
		guid_next = sum - (kcnt_q + k2_times(word_data.tail));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= '0;
			wcnt_q <= '0;
			kcnt_q <= '0;
		end else if (word_take) begin
			if (word_data.term) begin
				hash_q <= '0;
				wcnt_q <= '0;
				kcnt_q <= '0;
			end else begin
				hash_q <= sum ^ (sum >> 61);
				wcnt_q <= wcnt_q + WcntWidth'(1);
				kcnt_q <= kcnt_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (word_take && word_data.term) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (word_take && word_data.term) begin
			guid_q <= guid_next;
		end
	end

	assign out_valid = out_valid_q;
	assign guid      = guid_q;

endmodule

// ===== sv/path_string_guid_hash_unit.sv =====
// Path: a terminator word passes the input register and the second-stage register, then sets out_valid.
// Throughput: one word beat per cycle; a waiting guid stalls the next terminator and the words behind it.
// Words without a terminator flow on while a guid waits in the result register.
// The accumulator's hash multiply and add close the loop through hash_q that sets the rate.
// Reset is asynchronous and active low; it clears the hash, the count and all valid flags.
module path_string_guid_hash_unit import psgh_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [WordWidth-1:0] text_word,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [HashWidth-1:0] guid
);

	logic       word_valid;
	psgh_word_t word_data;
	logic       word_take;

	// Folding and product stage.
	psgh_fold u_fold (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.text_word  (text_word),
		.word_valid (word_valid),
		.word_data  (word_data),
		.word_take  (word_take)
	);

	// Hash update and result register.
	psgh_accum u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.word_valid (word_valid),
		.word_data  (word_data),
		.word_take  (word_take),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.guid       (guid)
	);

endmodule

// ===== sv/psgh_checker.sv =====
// Port-level checks for the path string guid hash unit, bound to the top level.
module psgh_checker import psgh_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic [WordWidth-1:0] text_word,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [HashWidth-1:0] guid
);

	// A stalled word beat stays offered with the same value.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(text_word))
		else $error("word beat dropped or changed while stalled");

	// A stalled guid beat stays offered with the same value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(guid))
		else $error("guid beat dropped or changed while stalled");

	// Input back-pressure only ever comes from a stalled guid.
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without a waiting guid");

	// Once reset has been seen at an edge, no result is offered and the input is free.
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !out_valid && in_ready)
		else $error("outputs active during reset");

	// A guid can only be offered after some word has entered.
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready || in_valid, 2) || $past(out_valid, 1) ||
			!$past(arst_n, 2) || $past(in_valid, 3) || $past(in_valid, 2))
		else $error("guid offered with no word beat before it");

endmodule

bind path_string_guid_hash_unit psgh_checker u_psgh_checker (.*);

// ===== tb/sv/path_string_guid_hash_unit_tb.sv =====
// Self-checking testbench for the path string guid hash unit: directed words, then random paths.
module path_string_guid_hash_unit_tb import psgh_pkg::*; ();

	localparam logic [63:0] MulK1 = 64'h00000FB8C4D96501;
	localparam logic [63:0] MulKm = 64'h000000000633D5F1;
	localparam logic [63:0] MulK2 = 64'h00AE502812AA7333;

	localparam int unsigned RandomWords = 600;
	localparam int unsigned CycleLimit  = 200000;
	localparam int unsigned IdlePercent = 28;
	localparam int unsigned NumRows     = 21;

	// One row of the directed table; a typed guid is used where the answer is obvious.
	typedef struct packed {
		logic [31:0] word;
		logic        typed;
		logic [63:0] guid;
	} word_row_t;

	localparam word_row_t DirectedRows [NumRows] = '{
		'{32'h00000000, 1'b1, 64'h0},   // empty string straight after reset
		'{32'hFFFFFF00, 1'b1, 64'h0},   // empty string, junk after the terminator
		'{32'hFFFFFFFF, 1'b0, 64'h0},
		'{32'h00FFFFFF, 1'b0, 64'h0},   // terminator in the top byte
		'{32'h5C5C5C5C, 1'b0, 64'h0},   // four backslashes
		'{32'h0000005C, 1'b0, 64'h0},
		'{32'h615C415C, 1'b0, 64'h0},   // mixed case with backslashes
		'{32'h00005C61, 1'b0, 64'h0},
		'{32'h5D5C5D5C, 1'b0, 64'h0},   // borrow out of a backslash byte
		'{32'h5C5D5C5B, 1'b0, 64'h0},
		'{32'hDCDCDCDC, 1'b0, 64'h0},   // backslash pattern with the top bit set
		'{32'h5B5C5C5C, 1'b0, 64'h0},
		'{32'h80808080, 1'b0, 64'h0},
		'{32'h7F7F7F7F, 1'b0, 64'h0},
		'{32'h01010101, 1'b0, 64'h0},
		'{32'h01000100, 1'b0, 64'h0},   // terminator in the low byte, false flag above it
		'{32'h7A797861, 1'b0, 64'h0},
		'{32'h5A595841, 1'b0, 64'h0},
		'{32'h2F2E2D5C, 1'b0, 64'h0},
		'{32'h00010101, 1'b0, 64'h0},
		'{32'h5C5C5C00, 1'b1, 64'h0}    // empty string, backslashes after the terminator
	};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [WordWidth-1:0] text_word = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [HashWidth-1:0] guid;

	// Predicted state of the hash and the byte count.
	logic [63:0]  hash_acc = '0;
	logic [31:0]  char_count = '0;
	logic [63:0]  pending_guids [$];
	int unsigned  cycles = 0;
	int unsigned  words_sent = 0;
	int unsigned  fails = 0;
	logic         calm;

	path_string_guid_hash_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.text_word (text_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.guid      (guid)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// A window of cycles in which neither side idles.
	assign calm = (cycles >= 400) && (cycles < 650);

	// Folds one word into the hash; returns 1 with the guid when the word ends the string.
	function automatic logic hash_word(input logic [31:0] w, output logic [63:0] g);
		logic [31:0] x;
		logic [31:0] flags;
		logic [31:0] folded;
		logic [31:0] z;
		logic [31:0] low;
		logic [31:0] keep;
		logic [31:0] k;
		logic [31:0] total;
		logic [63:0] t;
		logic [63:0] s;
		x = w ^ 32'h5C5C5C5C;
		flags = (~x >> 7) & ((x - 32'h01010101) >> 7) & 32'h01010101;
		folded = (w - 32'd45 * flags) & 32'hDFDFDFDF;
		z = ~w & (w - 32'h01010101) & 32'h80808080;
		g = '0;
		if (z == 32'd0) begin
			t = (MulK1 * {32'd0, folded}) >> 24;
			s = t + MulKm * hash_acc;
			hash_acc = s ^ (s >> 61);
			char_count = char_count + 32'd4;
			return 1'b0;
		end
		low = z & (~z + 32'd1);
		keep = low - 32'd1;
		case (low)
			32'h00000080: k = 32'd0;
			32'h00008000: k = 32'd1;
			32'h00800000: k = 32'd2;
			default:      k = 32'd3;
		endcase
		total = char_count + k;
		g = MulKm * hash_acc + ((MulK1 * {32'd0, folded & keep}) >> 24)
			- MulK2 * {32'd0, total};
		hash_acc = '0;
		char_count = '0;
		return 1'b1;
	endfunction

	// A non-zero byte drawn mostly from the characters seen in paths.
	function automatic logic [7:0] path_char();
		logic [7:0] c;
		case ($urandom_range(0, 7))
			0:       c = 8'h5C;
			1:       c = 8'h2F;
			2:       c = 8'h41 + 8'($urandom_range(0, 25));
			3, 4:    c = 8'h61 + 8'($urandom_range(0, 25));
			5:       c = 8'h2D + 8'($urandom_range(0, 12));
			default: c = 8'($urandom_range(1, 255));
		endcase
		return c;
	endfunction

	// Sends one word beat, with random idle cycles first, and records any guid it causes.
	task automatic send_word(input logic [31:0] w, input logic typed, input logic [63:0] typed_guid);
		logic [63:0] g;
		while (!calm && $urandom_range(0, 99) < IdlePercent) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		text_word <= w;
		do
			@(posedge clk);
		while (!in_ready);
		words_sent++;
		if (hash_word(w, g))
			pending_guids.push_back(typed ? typed_guid : g);
	endtask

	// Stimulus: reset, the directed table, then random strings and noise.
	initial begin
		logic [31:0] w;
		int unsigned len;
		int unsigned term_at;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < NumRows; i++)
			send_word(DirectedRows[i].word, DirectedRows[i].typed, DirectedRows[i].guid);
		while (words_sent < NumRows + RandomWords) begin
			if ($urandom_range(0, 99) < 85) begin
				// Well-formed string: body words without a zero byte, then a terminator word.
				len = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
				for (int n = 0; n < len; n++) begin
					for (int b = 0; b < 4; b++)
						w[8*b +: 8] = path_char();
					send_word(w, 1'b0, '0);
				end
				term_at = $urandom_range(0, 3);
				w = $urandom;
				for (int b = 0; b < 4; b++)
					if (b < term_at)
						w[8*b +: 8] = path_char();
				w[8*term_at +: 8] = 8'h00;
				send_word(w, 1'b0, '0);
			end else begin
				// Noise: raw random words, which may or may not end a string.
				len = $urandom_range(1, 4);
				for (int n = 0; n < len; n++)
					send_word($urandom, 1'b0, '0);
			end
		end
		in_valid <= 1'b0;
		while (pending_guids.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (fails == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// Result side: compare each guid beat with the oldest prediction, then pick the next ready.
	always @(posedge clk) begin : take_guid
		logic [63:0] want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_guids.size() == 0) begin
				$display("%0t: guid %h arrived with none expected", $time, guid);
				fails++;
			end else begin
				want = pending_guids.pop_front();
				if (guid !== want) begin
					$display("%0t: guid mismatch, expected %h, actual %h", $time, want, guid);
					fails++;
				end
			end
		end
		out_ready <= arst_n && (calm || ($urandom_range(0, 99) >= IdlePercent));
	end

	// Watchdog on the length of the run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CycleLimit) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

endmodule

// ===== sim.f =====
sv/psgh_pkg.sv
sv/psgh_fold.sv
sv/psgh_accum.sv
sv/path_string_guid_hash_unit.sv
sv/psgh_checker.sv
tb/sv/path_string_guid_hash_unit_tb.sv
